/* hw/rtl/hmf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hmf_pkg
// Shared types, constants and helpers of the Hill-type muscle force step.
// ----------------------------------------------------------------------------
package hmf_pkg;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic signed [33:0] Q_ONE        = 34'sd65536;
   localparam logic signed [33:0] SLACK_LEN    = 34'sd91750;
   localparam logic signed [31:0] ACTIVE_LO    = 32'sd32768;
   localparam logic signed [31:0] ACTIVE_HI    = 32'sd98304;
   localparam logic signed [31:0] ACTIVE_FLOOR = 32'sd7;
   localparam logic signed [31:0] ACTIVE_ONE   = 32'sd65536;
   localparam logic signed [31:0] VN_FLOOR     = -32'sd65536;
   localparam logic signed [31:0] S32_MAX      = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN      = 32'sh8000_0000;

   typedef enum logic [2:0] {
      R_MAX_FORCE, R_OPT_LEN, R_MAX_VEL, R_TAU_RISE,
      R_TAU_FALL, R_SHAPE_SHORT, R_SHAPE_LONG, R_LONG_ASYM
   } reg_idx_type;

   typedef enum logic [4:0] {
      ST_LN, ST_VEL, ST_VN, ST_RATE, ST_ACTM, ST_SLK, ST_ACTV,
      ST_RATIO, ST_SUB, ST_ASV, ST_FVL, ST_T, ST_FVS,
      ST_P1, ST_P2, ST_P3, ST_P4
   } step_type;

   typedef struct packed {
      logic [30:0] max_force;
      logic [30:0] optimal_length;
      logic [30:0] max_velocity;
      logic [30:0] tau_rise;
      logic [30:0] tau_fall;
      logic [30:0] shape_short;
      logic [30:0] shape_long;
      logic [30:0] long_asymptote;
   } cfg_type;

   typedef struct packed {
      logic     load;
      logic     start;
      step_type step;
      logic     commit;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic rest;
      logic vn_low;
      logic vn_pos;
   } stat_type;

   function automatic logic is_div(input step_type s);
      logic r;
      case (s) inside
         ST_LN, ST_VEL, ST_VN, ST_RATE, ST_RATIO, ST_FVL, ST_T, ST_FVS: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      logic signed [31:0] r;
      if (x > 66'sh0_7FFF_FFFF)       r = S32_MAX;
      else if (x < -66'sh0_8000_0000) r = S32_MIN;
      else                            r = x[31:0];
      return r;
   endfunction

   function automatic logic signed [33:0] ext34(input logic signed [31:0] x);
      return {{2{x[31]}}, x};
   endfunction

   function automatic logic signed [33:0] ext34u(input logic [30:0] x);
      return {3'b000, x};
   endfunction

   function automatic logic signed [65:0] ext66(input logic signed [31:0] x);
      return {{34{x[31]}}, x};
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/hmf_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hmf_req_if / hmf_rsp_if
// Valid/ready channels carrying one tick request and one force result.
// ----------------------------------------------------------------------------
interface hmf_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic signed [31:0] muscle_length;
   logic signed [31:0] excitation;
   logic [30:0]        time_step;

   modport source (output valid, action, muscle_length, excitation, time_step,
                   input ready);
   modport sink   (input valid, action, muscle_length, excitation, time_step,
                   output ready);
endinterface

interface hmf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] velocity;
   logic signed [31:0] length_norm;
   logic signed [31:0] velocity_norm;
   logic signed [31:0] activation_out;
   logic signed [31:0] passive_norm;
   logic signed [31:0] active_norm;
   logic signed [31:0] velocity_factor;
   logic signed [31:0] total_force;

   modport source (output valid, velocity, length_norm, velocity_norm,
                   activation_out, passive_norm, active_norm, velocity_factor,
                   total_force, input ready);
   modport sink   (input valid, velocity, length_norm, velocity_norm,
                   activation_out, passive_norm, active_norm, velocity_factor,
                   total_force, output ready);
endinterface
`default_nettype wire

/* hw/rtl/hmf_csr.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hmf_csr
// APB-style register bank holding the muscle parameters.
// ----------------------------------------------------------------------------
module hmf_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [hmf_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [hmf_pkg::CSR_DW-1:0] csr_pwdata,
   output      logic [hmf_pkg::CSR_DW-1:0] csr_prdata,
   output      logic                      csr_pready,
   output      hmf_pkg::cfg_type          cfg
);
   import hmf_pkg::*;

   cfg_type     cfg_ff;
   logic        wr_en;
   reg_idx_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = reg_idx_type'(csr_paddr[CSR_AW-1:2]);
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_force      <= 31'd65536;
         cfg_ff.optimal_length <= 31'd65536;
         cfg_ff.max_velocity   <= 31'd65536;
         cfg_ff.tau_rise       <= 31'd655;
         cfg_ff.tau_fall       <= 31'd2621;
         cfg_ff.shape_short    <= 31'd9830;
         cfg_ff.shape_long     <= 31'd9830;
         cfg_ff.long_asymptote <= 31'd98304;
      end else if (wr_en) begin
         unique case (idx)
            R_MAX_FORCE:   cfg_ff.max_force      <= csr_pwdata[30:0];
            R_OPT_LEN:     cfg_ff.optimal_length <= csr_pwdata[30:0];
            R_MAX_VEL:     cfg_ff.max_velocity   <= csr_pwdata[30:0];
            R_TAU_RISE:    cfg_ff.tau_rise       <= csr_pwdata[30:0];
            R_TAU_FALL:    cfg_ff.tau_fall       <= csr_pwdata[30:0];
            R_SHAPE_SHORT: cfg_ff.shape_short    <= csr_pwdata[30:0];
            R_SHAPE_LONG:  cfg_ff.shape_long     <= csr_pwdata[30:0];
            R_LONG_ASYM:   cfg_ff.long_asymptote <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         R_MAX_FORCE:   csr_prdata = {1'b0, cfg_ff.max_force};
         R_OPT_LEN:     csr_prdata = {1'b0, cfg_ff.optimal_length};
         R_MAX_VEL:     csr_prdata = {1'b0, cfg_ff.max_velocity};
         R_TAU_RISE:    csr_prdata = {1'b0, cfg_ff.tau_rise};
         R_TAU_FALL:    csr_prdata = {1'b0, cfg_ff.tau_fall};
         R_SHAPE_SHORT: csr_prdata = {1'b0, cfg_ff.shape_short};
         R_SHAPE_LONG:  csr_prdata = {1'b0, cfg_ff.shape_long};
         R_LONG_ASYM:   csr_prdata = {1'b0, cfg_ff.long_asymptote};
         default:       csr_prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

/* hw/rtl/hmf_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hmf_ctrl
// Sequencer: walks the datapath through the divide/multiply steps of a tick.
// ----------------------------------------------------------------------------
module hmf_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      hmf_pkg::cmd_type  cmd,
   input  wire hmf_pkg::stat_type stat
);
   import hmf_pkg::*;

   typedef enum logic [1:0] {C_IDLE, C_ISSUE, C_WAIT, C_OUT} state_type;

   state_type state_ff;
   step_type  step_ff;
   logic      rsp_valid_ff;
   step_type  step_next;
   logic      commit;

   assign req_ready  = (state_ff == C_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign commit     = (state_ff == C_OUT) && (!rsp_valid_ff || rsp_ready);
   assign cmd.load   = req_valid && req_ready;
   assign cmd.start  = (state_ff == C_ISSUE);
   assign cmd.step   = step_ff;
   assign cmd.commit = commit;

   always_comb begin
      unique case (step_ff)
         ST_LN:    step_next = ST_VEL;
         ST_VEL:   step_next = ST_VN;
         ST_VN:    step_next = ST_RATE;
         ST_RATE:  step_next = ST_ACTM;
         ST_ACTM:  step_next = ST_SLK;
         ST_SLK:   step_next = ST_ACTV;
         // velocity factor branch: shortening past max velocity (stays zero), lengthening, shortening
         ST_ACTV:  step_next = stat.vn_low ? ST_P1 : (stat.vn_pos ? ST_RATIO : ST_T);
         ST_RATIO: step_next = ST_SUB;
         ST_SUB:   step_next = ST_ASV;
         ST_ASV:   step_next = ST_FVL;
         ST_FVL:   step_next = ST_P1;
         ST_T:     step_next = ST_FVS;
         ST_FVS:   step_next = ST_P1;
         ST_P1:    step_next = ST_P2;
         ST_P2:    step_next = ST_P3;
         ST_P3:    step_next = ST_P4;
         ST_P4:    step_next = ST_LN;
         default:  step_next = ST_LN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         step_ff      <= ST_LN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit)         rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            C_IDLE: begin
               if (req_valid) begin
                  state_ff <= C_ISSUE;
                  step_ff  <= ST_LN;
               end
            end
            C_ISSUE: state_ff <= C_WAIT;
            C_WAIT: begin
               if (stat.done) begin
                  if ((step_ff == ST_LN && stat.rest) || step_ff == ST_P4) begin
                     state_ff <= C_OUT;
                  end else begin
                     state_ff <= C_ISSUE;
                     step_ff  <= step_next;
                  end
               end
            end
            C_OUT: begin
               if (commit) state_ff <= C_IDLE;
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/hmf_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hmf_dp
// Datapath: operand selection, shared restoring divider, shared multiplier,
// working registers, muscle state and the result register.
// ----------------------------------------------------------------------------
module hmf_dp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire hmf_pkg::cfg_type   cfg,
   input  wire hmf_pkg::cmd_type   cmd,
   output      hmf_pkg::stat_type  stat,
   input  wire logic               in_action,
   input  wire logic signed [31:0] in_muscle_length,
   input  wire logic signed [31:0] in_excitation,
   input  wire logic [30:0]        in_time_step,
   output      logic signed [31:0] out_velocity,
   output      logic signed [31:0] out_length_norm,
   output      logic signed [31:0] out_velocity_norm,
   output      logic signed [31:0] out_activation,
   output      logic signed [31:0] out_passive_norm,
   output      logic signed [31:0] out_active_norm,
   output      logic signed [31:0] out_velocity_factor,
   output      logic signed [31:0] out_total_force
);
   import hmf_pkg::*;

   typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_FIN} unit_type;

   // tick inputs and muscle state
   logic               action_ff;
   logic signed [31:0] len_ff, exc_ff;
   logic [30:0]        dt_ff;
   logic signed [31:0] prev_ff, actst_ff;

   // working values
   logic signed [31:0] ln_ff, vel_ff, vn_ff, act_ff, passive_ff, active_ff;
   logic signed [31:0] fv_ff, total_ff, tmp_ff, sub_ff;
   logic signed [33:0] num_ff;

   // shared arithmetic unit
   unit_type           unit_ff;
   logic signed [65:0] prod_ff;
   logic [33:0]        rem_ff, den_ff;
   logic [31:0]        quo_ff;
   logic               neg_ff;
   logic [4:0]         cnt_ff;
   logic               done_ff;
   logic signed [31:0] res_ff;

   logic signed [33:0] op_a, op_b, slack;
   logic [33:0]        mag_a, mag_b;
   logic [34:0]        trial;
   logic signed [65:0] mul_adj, res66;
   logic               slack_pos, ln_in_range;

   assign slack       = ext34(ln_ff) - SLACK_LEN;
   assign slack_pos   = !slack[33] && (slack != '0);
   assign ln_in_range = (ln_ff >= ACTIVE_LO) && (ln_ff <= ACTIVE_HI);

   assign stat.done   = done_ff;
   assign stat.rest   = action_ff;
   assign stat.vn_low = (vn_ff < VN_FLOOR);
   assign stat.vn_pos = (vn_ff > 32'sd0);

   always_comb begin
      unique case (cmd.step)
         ST_LN:    begin op_a = ext34(len_ff);  op_b = ext34u(cfg.optimal_length); end
         ST_VEL:   begin op_a = ext34(len_ff) - ext34(prev_ff); op_b = ext34u(dt_ff); end
         ST_VN:    begin op_a = ext34(vel_ff);  op_b = ext34u(cfg.max_velocity); end
         ST_RATE:  begin
            op_a = ext34(exc_ff) - ext34(actst_ff);
            op_b = (exc_ff >= actst_ff) ? ext34u(cfg.tau_rise) : ext34u(cfg.tau_fall);
         end
         ST_ACTM:  begin op_a = ext34(tmp_ff);  op_b = ext34u(dt_ff); end
         ST_SLK:   begin op_a = slack;          op_b = slack; end
         ST_ACTV:  begin
            op_a = ext34(ln_ff) - Q_ONE;
            op_b = ext34(ln_ff) - Q_ONE;
         end
         ST_RATIO: begin
            op_a = Q_ONE - ext34u(cfg.long_asymptote);
            op_b = Q_ONE + ext34u(cfg.shape_long);
         end
         ST_SUB:   begin op_a = {4'b0000, cfg.shape_long[30:1]}; op_b = ext34(tmp_ff); end
         ST_ASV:   begin op_a = ext34u(cfg.long_asymptote); op_b = ext34(vn_ff); end
         ST_FVL:   begin op_a = num_ff; op_b = ext34(sub_ff) - ext34(vn_ff); end
         ST_T:     begin op_a = ext34(vn_ff);  op_b = ext34u(cfg.shape_short); end
         ST_FVS:   begin op_a = Q_ONE + ext34(vn_ff); op_b = Q_ONE - ext34(tmp_ff); end
         ST_P1:    begin op_a = ext34(act_ff); op_b = ext34u(cfg.max_force); end
         ST_P2:    begin op_a = ext34(tmp_ff); op_b = ext34(active_ff); end
         ST_P3:    begin op_a = ext34(tmp_ff); op_b = ext34(fv_ff); end
         ST_P4:    begin op_a = ext34u(cfg.max_force); op_b = ext34(passive_ff); end
         default:  begin op_a = '0; op_b = '0; end
      endcase
   end

   assign mag_a   = op_a[33] ? 34'(-op_a) : 34'(op_a);
   assign mag_b   = op_b[33] ? 34'(-op_b) : 34'(op_b);
   assign trial   = {rem_ff, quo_ff[31]};
   // truncate toward zero on the way down by 2^16
   assign mul_adj = prod_ff + (prod_ff[65] ? 66'sd65535 : 66'sd0);
   assign res66   = ext66(res_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= U_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (unit_ff)
            U_IDLE: begin
               if (cmd.start) begin
                  if (!is_div(cmd.step)) begin
                     unit_ff <= U_MUL;
                  end else if (mag_a == '0) begin
                     res_ff  <= '0;
                     done_ff <= 1'b1;
                  end else if ({16'b0, mag_a} >= {mag_b, 16'b0}) begin
                     // quotient beyond 32 bits, or zero divisor
                     res_ff  <= (op_a[33] ^ op_b[33]) ? S32_MIN : S32_MAX;
                     done_ff <= 1'b1;
                  end else begin
                     unit_ff <= U_DIV;
                  end
               end
            end
            U_MUL: begin
               res_ff  <= sat32(mul_adj >>> 16);
               done_ff <= 1'b1;
               unit_ff <= U_IDLE;
            end
            U_DIV: begin
               if (cnt_ff == 5'd31) unit_ff <= U_FIN;
            end
            U_FIN: begin
               if (neg_ff) res_ff <= (quo_ff > 32'h8000_0000) ? S32_MIN : 32'(-quo_ff);
               else        res_ff <= quo_ff[31] ? S32_MAX : quo_ff;
               done_ff <= 1'b1;
               unit_ff <= U_IDLE;
            end
            default: unit_ff <= U_IDLE;
         endcase
      end
   end

   // divider and multiplier payload
   always_ff @(posedge clock) begin
      if (unit_ff == U_IDLE && cmd.start) begin
         prod_ff <= $signed(op_a[32:0]) * $signed(op_b[32:0]);
         rem_ff  <= {16'b0, mag_a[33:16]};
         quo_ff  <= {mag_a[15:0], 16'b0};
         den_ff  <= mag_b;
         neg_ff  <= op_a[33] ^ op_b[33];
         cnt_ff  <= '0;
      end else if (unit_ff == U_DIV) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= 34'(trial - {1'b0, den_ff});
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= trial[33:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 5'd1;
      end
   end

   // muscle state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         actst_ff <= '0;
      end else if (cmd.commit) begin
         prev_ff  <= len_ff;
         actst_ff <= act_ff;
      end
   end

   // tick capture, write-back and result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff  <= in_action;
         len_ff     <= in_muscle_length;
         exc_ff     <= in_excitation;
         dt_ff      <= in_time_step;
         ln_ff      <= '0;
         vel_ff     <= '0;
         vn_ff      <= '0;
         act_ff     <= '0;
         passive_ff <= '0;
         active_ff  <= '0;
         fv_ff      <= '0;
         total_ff   <= '0;
      end else if (done_ff) begin
         case (cmd.step)
            ST_LN:   ln_ff  <= res_ff;
            ST_VEL:  vel_ff <= res_ff;
            ST_VN:   vn_ff  <= res_ff;
            ST_ACTM: act_ff <= sat32(ext66(actst_ff) + res66);
            ST_SLK:  passive_ff <= slack_pos ?
                        sat32((res66 <<< 5) + (res66 <<< 4) + (res66 <<< 1)) : 32'sd0;
            ST_ACTV: active_ff <= ln_in_range ? (ACTIVE_ONE - (res_ff <<< 2)) : ACTIVE_FLOOR;
            ST_SUB:  sub_ff <= res_ff;
            ST_ASV:  num_ff <= ext34(sub_ff) - ext34(res_ff);
            ST_FVL, ST_FVS: fv_ff <= res_ff;
            ST_P4:   total_ff <= sat32(ext66(tmp_ff) + res66);
            default: tmp_ff <= res_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_velocity        <= vel_ff;
         out_length_norm     <= ln_ff;
         out_velocity_norm   <= vn_ff;
         out_activation      <= act_ff;
         out_passive_norm    <= passive_ff;
         out_active_norm     <= active_ff;
         out_velocity_factor <= fv_ff;
         out_total_force     <= total_ff;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/hill_muscle_force_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hill_muscle_force_step
// One tick of a Hill-type muscle: velocity, activation, force terms, total.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | beat
//  req_bus | in  | valid/ready      | action, length, excitation, time step
//  rsp_bus | out | valid/ready      | eight Q16.16 force results
//  csr_*   | in  | APB setup/access | one 31-bit parameter per word
//
//  A tick runs four to six divides (one quotient bit per cycle in the shared
//  divider) and up to nine multiplies; a rest beat needs one divide.
//  One tick at a time; the next request is taken once the result sits in the
//  output register, even while that result still waits for rsp ready.
//  Synchronous reset clears the previous length and the activation.
// ----------------------------------------------------------------------------
module hill_muscle_force_step (
   input  wire logic                       clock,
   input  wire logic                       reset,
   hmf_req_if.sink                         req_bus,
   hmf_rsp_if.source                       rsp_bus,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [hmf_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [hmf_pkg::CSR_DW-1:0] csr_pwdata,
   output      logic [hmf_pkg::CSR_DW-1:0] csr_prdata,
   output      logic                       csr_pready
);
   import hmf_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   hmf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   hmf_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .stat                (stat),
      .in_action           (req_bus.action),
      .in_muscle_length    (req_bus.muscle_length),
      .in_excitation       (req_bus.excitation),
      .in_time_step        (req_bus.time_step),
      .out_velocity        (rsp_bus.velocity),
      .out_length_norm     (rsp_bus.length_norm),
      .out_velocity_norm   (rsp_bus.velocity_norm),
      .out_activation      (rsp_bus.activation_out),
      .out_passive_norm    (rsp_bus.passive_norm),
      .out_active_norm     (rsp_bus.active_norm),
      .out_velocity_factor (rsp_bus.velocity_factor),
      .out_total_force     (rsp_bus.total_force)
   );

endmodule
`default_nettype wire

/* dv/hmf_force_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hmf_force_checker
// Watches the request, result and register ports of the muscle force step,
// predicts every result from its own copy of the state and registers, and
// compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module hmf_force_checker
   import hmf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   hmf_req_if                     req_mon,
   hmf_rsp_if                     rsp_mon,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic              csr_pready,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output int                     fail_count,
   output int                     pending,
   output int                     ticks_seen,
   output int                     rests_seen
);

   typedef struct packed {
      logic signed [31:0] velocity;
      logic signed [31:0] length_norm;
      logic signed [31:0] velocity_norm;
      logic signed [31:0] activation_out;
      logic signed [31:0] passive_norm;
      logic signed [31:0] active_norm;
      logic signed [31:0] velocity_factor;
      logic signed [31:0] total_force;
   } force_beat_type;

   localparam longint ONE = 65536;
   localparam longint LMAX = 64'sd2147483647;
   localparam longint LMIN = -64'sd2147483648;

   longint         prm [8];
   longint         last_len, act_state;
   force_beat_type force_q[$];

   function automatic longint clip(input longint x);
      if (x > LMAX) return LMAX;
      if (x < LMIN) return LMIN;
      return x;
   endfunction

   function automatic longint fx_mul(input longint a, input longint b);
      return clip((a * b) / ONE);
   endfunction

   function automatic longint fx_div(input longint a, input longint b);
      if (b == 0) return (a > 0) ? LMAX : ((a < 0) ? LMIN : 0);
      return clip((a * ONE) / b);
   endfunction

   function automatic longint hill_factor(input longint v);
      longint ratio, sub;
      if (v < -ONE) return 0;
      if (v > 0) begin
         ratio = fx_div(ONE - prm[R_LONG_ASYM], ONE + prm[R_SHAPE_LONG]);
         sub   = fx_mul(prm[R_SHAPE_LONG] / 2, ratio);
         return fx_div(sub - fx_mul(prm[R_LONG_ASYM], v), sub - v);
      end
      return fx_div(ONE + v, ONE - fx_div(v, prm[R_SHAPE_SHORT]));
   endfunction

   function automatic force_beat_type muscle_tick(input logic rest, input longint len,
                                                  input longint exc, input longint dt);
      force_beat_type r;
      longint vel, vn, ln, tau, act, slack, passive, active, fv, total;
      r  = '0;
      ln = fx_div(len, prm[R_OPT_LEN]);
      r.length_norm = ln[31:0];
      if (rest) begin
         last_len  = len;
         act_state = 0;
         return r;
      end
      vel   = fx_div(len - last_len, dt);
      vn    = fx_div(vel, prm[R_MAX_VEL]);
      tau   = (exc >= act_state) ? prm[R_TAU_RISE] : prm[R_TAU_FALL];
      act   = clip(act_state + fx_mul(fx_div(exc - act_state, tau), dt));
      slack = ln - 91750;
      passive = (slack > 0) ? clip(fx_mul(slack, slack) * 50) : 0;
      if (ln >= 32768 && ln <= 98304)
         active = ONE - fx_mul(ln - ONE, ln - ONE) * 4;
      else
         active = 7;
      fv    = hill_factor(vn);
      total = fx_mul(fx_mul(fx_mul(act, prm[R_MAX_FORCE]), active), fv);
      total = clip(total + fx_mul(prm[R_MAX_FORCE], passive));
      last_len  = len;
      act_state = act;
      r.velocity        = vel[31:0];
      r.velocity_norm   = vn[31:0];
      r.activation_out  = act[31:0];
      r.passive_norm    = passive[31:0];
      r.active_norm     = active[31:0];
      r.velocity_factor = fv[31:0];
      r.total_force     = total[31:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d (0x%08h), got %0d (0x%08h)", name, want, want, got, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      force_beat_type want;
      if (reset) begin
         prm[R_MAX_FORCE]   = 65536; prm[R_OPT_LEN]     = 65536;
         prm[R_MAX_VEL]     = 65536; prm[R_TAU_RISE]    = 655;
         prm[R_TAU_FALL]    = 2621;  prm[R_SHAPE_SHORT] = 9830;
         prm[R_SHAPE_LONG]  = 9830;  prm[R_LONG_ASYM]   = 98304;
         last_len = 0; act_state = 0;
         force_q.delete();
         fail_count = 0;
         ticks_seen = 0;
         rests_seen = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[4:2] <= 7)
            prm[csr_paddr[4:2]] = longint'(csr_pwdata[30:0]);
         if (req_mon.valid && req_mon.ready) begin
            force_q = {force_q, muscle_tick(req_mon.action, longint'(req_mon.muscle_length),
                                            longint'(req_mon.excitation),
                                            longint'(req_mon.time_step))};
            if (req_mon.action) rests_seen++;
            else                ticks_seen++;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (force_q.size() == 0) begin
               $error("result beat with no prediction waiting");
               fail_count++;
            end else begin
               want = force_q.pop_front();
               check_field("velocity",        want.velocity,        rsp_mon.velocity);
               check_field("length_norm",     want.length_norm,     rsp_mon.length_norm);
               check_field("velocity_norm",   want.velocity_norm,   rsp_mon.velocity_norm);
               check_field("activation_out",  want.activation_out,  rsp_mon.activation_out);
               check_field("passive_norm",    want.passive_norm,    rsp_mon.passive_norm);
               check_field("active_norm",     want.active_norm,     rsp_mon.active_norm);
               check_field("velocity_factor", want.velocity_factor, rsp_mon.velocity_factor);
               check_field("total_force",     want.total_force,     rsp_mon.total_force);
            end
         end
      end
      pending = force_q.size();
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives muscle tick and rest beats through four register settings with
// varied idling and back-pressure; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
   import hmf_pkg::*;

   logic              clock;
   logic              reset;
   logic              csr_psel, csr_penable, csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;
   int                fail_count, pending, ticks_seen, rests_seen;
   int                send_idle, recv_idle;
   int                hold_ask, hold_seen, hold_left;
   longint            track_len, opt_len;

   hmf_req_if req_bus ();
   hmf_rsp_if rsp_bus ();

   hill_muscle_force_step u_top (
      .clock, .reset, .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   hmf_force_checker u_checker (
      .clock, .reset, .req_mon(req_bus), .rsp_mon(rsp_bus),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .fail_count, .pending, .ticks_seen, .rests_seen
   );

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // receiver: random stalls, plus a long hold-off when asked
   always @(negedge clock) begin
      if (hold_ask != hold_seen) begin
         hold_seen = hold_ask;
         hold_left = 3000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready = 1'b0;
      end else begin
         rsp_bus.ready = ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic write_param(input reg_idx_type idx, input logic [30:0] value);
      @(negedge clock);
      csr_psel = 1'b1; csr_penable = 1'b0; csr_pwrite = 1'b1;
      csr_paddr = CSR_AW'(idx) << 2; csr_pwdata = {1'b0, value};
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      wait (pending == 0);
      repeat (300) @(posedge clock);
   endtask

   task automatic load_params(input logic [30:0] f, input logic [30:0] l,
                              input logic [30:0] v, input logic [30:0] tr,
                              input logic [30:0] tf, input logic [30:0] ss,
                              input logic [30:0] sl, input logic [30:0] la);
      drain();
      write_param(R_MAX_FORCE, f);   write_param(R_OPT_LEN, l);
      write_param(R_MAX_VEL, v);     write_param(R_TAU_RISE, tr);
      write_param(R_TAU_FALL, tf);   write_param(R_SHAPE_SHORT, ss);
      write_param(R_SHAPE_LONG, sl); write_param(R_LONG_ASYM, la);
      opt_len = l;
   endtask

   task automatic send_beat(input logic act, input logic signed [31:0] len,
                            input logic signed [31:0] exc, input logic [30:0] dt);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.action = act; req_bus.muscle_length = len;
      req_bus.excitation = exc; req_bus.time_step = dt;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   function automatic logic signed [31:0] to32(input longint x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   // mostly smooth length trajectories around the optimum, some noise
   task automatic random_beat();
      int     pick;
      longint step;
      logic [30:0] dt;
      logic signed [31:0] exc;
      pick = $urandom_range(99);
      if (pick < 5) begin
         track_len = (opt_len * $urandom_range(19660, 117964)) / 65536;
         send_beat(1'b1, to32(track_len), $urandom, 31'($urandom));
      end else if (pick < 15) begin
         send_beat(1'($urandom_range(1)), $urandom, $urandom, 31'($urandom));
      end else begin
         step = (opt_len * longint'(int'($urandom_range(0, 4096)) - 2048)) / 65536;
         if ($urandom_range(9) == 0) step = step * 16;
         track_len = track_len + step;
         if (track_len > opt_len * 2 || track_len < opt_len / 4) track_len = opt_len;
         dt  = ($urandom_range(49) == 0) ? 31'd0 : 31'($urandom_range(1, 6553));
         exc = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 65536);
         send_beat(1'b0, to32(track_len), exc, dt);
      end
   endtask

   task automatic random_run(input int n);
      repeat (n) random_beat();
   endtask

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      req_bus.valid = 1'b0; req_bus.action = 1'b0; req_bus.muscle_length = '0;
      req_bus.excitation = '0; req_bus.time_step = '0;
      rsp_bus.ready = 1'b0;
      send_idle = 33; recv_idle = 79;
      hold_ask = 0; hold_seen = 0; hold_left = 0;
      opt_len = 65536; track_len = 65536;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // typical muscle
      load_params(31'd6553600, 31'd65536, 31'd655360, 31'd655, 31'd2621,
                  31'd16384, 31'd9830, 31'd98304);
      send_beat(1'b1, 32'sd65536, 32'sd0, 31'd655);
      send_beat(1'b0, 32'sd65536, 32'sd65536, 31'd655);
      send_beat(1'b0, 32'sd65536, 32'sd65536, 31'd0);           // zero step, still
      send_beat(1'b0, 32'sd70000, 32'sd0, 31'd0);               // zero step, lengthening
      send_beat(1'b0, 32'sd60000, 32'sd0, 31'd0);               // zero step, shortening
      send_beat(1'b0, 32'sd32768, 32'sd65536, 31'd655);         // bottom of parabola
      send_beat(1'b0, 32'sd98304, 32'sd65536, 31'd655);         // top of parabola
      send_beat(1'b0, 32'sd32767, 32'sd0, 31'd655);             // floor below
      send_beat(1'b0, 32'sd98305, 32'sd0, 31'd655);
      send_beat(1'b0, 32'sd91750, 32'sd65536, 31'd655);         // slack edge
      send_beat(1'b0, 32'sd131072, 32'sd65536, 31'd655);        // passive force
      send_beat(1'b0, 32'sd20000, 32'sd65536, 31'd1);           // fast shortening, vn < -1
      send_beat(1'b0, 32'sd65536, 32'sd65536, 31'd6553);        // lengthening branch
      send_beat(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
      send_beat(1'b0, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF);
      send_beat(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'd1);
      send_beat(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'd0);
      send_beat(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF);
      send_beat(1'b0, 32'sd0, 32'sd0, 31'd0);
      send_beat(1'b1, 32'sd65536, 32'sd0, 31'd0);
      // sender pauses until every result is back
      drain();
      track_len = 65536;
      random_run(180);

      // largest registers
      send_idle = 79; recv_idle = 33;
      load_params('1, '1, '1, '1, '1, '1, '1, '1);
      track_len = opt_len;
      random_run(60);
      hold_ask++;
      random_run(120);

      // smallest registers
      send_idle = 0; recv_idle = 0;
      load_params(31'd1, 31'd1, 31'd1, 31'd1, 31'd1, 31'd1, 31'd0, 31'd0);
      track_len = opt_len;
      random_run(180);

      // a stiffer, slower muscle
      load_params(31'd32768000, 31'd98304, 31'd131072, 31'd3276, 31'd328,
                  31'd32768, 31'd65536, 31'd131072);
      track_len = opt_len;
      random_run(180);

      drain();
      $display("Covered %0d tick beats and %0d rest beats over four register settings,",
               ticks_seen, rests_seen);
      $display("with sender and receiver stalls, a long result hold-off and drain pauses.");
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* hill_muscle_force_step.f */
hw/rtl/hmf_pkg.sv
hw/rtl/hmf_if.sv
hw/rtl/hmf_csr.sv
hw/rtl/hmf_ctrl.sv
hw/rtl/hmf_dp.sv
hw/rtl/hill_muscle_force_step.sv
dv/hmf_force_checker.sv
dv/testbench.sv
